@@ sv/pid_controller_with_antiwindup_macros.svh @@
// Assertion macros for the PID controller block.
`ifndef PID_CONTROLLER_WITH_ANTIWINDUP_MACROS_SVH
`define PID_CONTROLLER_WITH_ANTIWINDUP_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset.
`define PID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define PID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/pid_pkg.sv @@
// Package of the PID controller: microcode types, control word ROM, register indexes.
package pid_pkg;

  localparam int PID_FRAC_BITS = 16;
  localparam int UC_STEP_W     = 3;
  localparam int CFG_IDX_W     = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP    = 3'd0,
    REG_INTEG   = 3'd1,
    REG_DERIV   = 3'd2,
    REG_FILTER  = 3'd3,
    REG_LIM_EN  = 3'd4,
    REG_UPPER   = 3'd5,
    REG_LOWER   = 3'd6,
    REG_PERIOD  = 3'd7
  } cfg_idx_t;

  // Multiplier operand A select
  typedef enum logic [2:0] {
    MA_N, MA_P, MA_I, MA_D, MA_PER, MA_DN
  } mula_t;

  // Multiplier operand B select
  typedef enum logic [2:0] {
    MB_FILT, MB_E, MB_INTEG, MB_N, MB_DIFF
  } mulb_t;

  // Destination of the scaled, saturated product
  typedef enum logic [2:0] {
    WB_NONE, WB_T, WB_ACC_LOAD, WB_ACC_ADD, WB_DN, WB_INTEG
  } wb_t;

  // Step condition: run freely, wait for an input item, wait for output room
  typedef enum logic [1:0] {
    COND_NONE, COND_IN, COND_OUT
  } cond_t;

  typedef struct packed {
    mula_t                ma;
    mulb_t                mb;
    wb_t                  wb;
    logic                 do_diff;
    logic                 do_filt;
    logic                 do_out;
    cond_t                cond;
    logic                 jump;
    logic [UC_STEP_W-1:0] target;
  } ucw_t;

  // Control from sequencer to datapath
  typedef struct packed {
    ucw_t uc;
    logic go;
    logic busy;
  } pid_ctrl_t;

  // Control program. The product register is loaded every cycle from the
  // current step's operands; the step after reads it back.
  function automatic ucw_t uc_rom(input logic [UC_STEP_W-1:0] s);
    ucw_t w;
    w = '{ma: MA_N, mb: MB_FILT, wb: WB_NONE, do_diff: 1'b0, do_filt: 1'b0,
          do_out: 1'b0, cond: COND_NONE, jump: 1'b0, target: '0};
    case (s)
      3'd0: begin  // idle: take item, form N*filter
        w.cond = COND_IN;
      end
      3'd1: begin  // t = N*filter; start P*e
        w.wb = WB_T;  w.ma = MA_P;  w.mb = MB_E;
      end
      3'd2: begin  // acc = P*e; diff = e - t; start I*integral
        w.wb = WB_ACC_LOAD;  w.do_diff = 1'b1;  w.ma = MA_I;  w.mb = MB_INTEG;
      end
      3'd3: begin  // acc += I*integral; start D*N
        w.wb = WB_ACC_ADD;  w.ma = MA_D;  w.mb = MB_N;
      end
      3'd4: begin  // dn = D*N; start period*diff
        w.wb = WB_DN;  w.ma = MA_PER;  w.mb = MB_DIFF;
      end
      3'd5: begin  // t = period*diff; start dn*diff
        w.wb = WB_T;  w.ma = MA_DN;  w.mb = MB_DIFF;
      end
      3'd6: begin  // acc += dn*diff; filter += t; start period*e
        w.wb = WB_ACC_ADD;  w.do_filt = 1'b1;  w.ma = MA_PER;  w.mb = MB_E;
      end
      3'd7: begin  // result out, integral += period*e, back to idle
        w.wb = WB_INTEG;  w.do_out = 1'b1;  w.cond = COND_OUT;
        w.ma = MA_PER;  w.mb = MB_E;  w.jump = 1'b1;  w.target = '0;
      end
      default: begin
        w.cond = COND_IN;
      end
    endcase
    return w;
  endfunction

endpackage

@@ sv/pid_controller_with_antiwindup.sv @@
// PID controller top level: config registers, shared multiplier datapath, output register.
// A result is registered at the program's last step, which waits for the output register to be free.
// The single shared multiplier is stepped by the control program through seven products
//   in turn, so a new item is taken only once the program has finished the previous one.
// An item is taken only while the sequencer is idle; a waiting result does not block it.
// Reset (synchronous, rst_n low) restores register defaults and clears both states.
`include "pid_controller_with_antiwindup_macros.svh"

module pid_controller_with_antiwindup
  import pid_pkg::*;
#(
  parameter int FRAC_BITS = PID_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input item channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_error_value,
  // result item channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_control_output,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam logic signed [31:0] ONE_Q   = 32'(longint'(1) << FRAC_BITS);
  localparam logic [30:0]        N_RST   = 31'(longint'(100) << FRAC_BITS);
  localparam logic [16:0]        PER_RST = 17'(((longint'(1) << FRAC_BITS) + 500) / 1000);

  // Saturate helpers
  function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v[65:31] != {35{v[65]}}) begin
      r = v[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v[33:31] != {3{v[33]}}) begin
      r = v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic signed [31:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic        [30:0] filter_coeff_r;
  logic               limit_enable_r;
  logic signed [31:0] upper_limit_r, lower_limit_r;
  logic        [16:0] sample_period_r;

  // Datapath registers
  logic signed [31:0] e_r, t_r, diff_r, dn_r, integ_r, filt_r;
  logic signed [33:0] acc_r;
  logic signed [65:0] prod_r;
  logic signed [31:0] out_r;
  logic               out_valid_r;

  pid_ctrl_t          ctrl;
  logic               out_free;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_sh;
  logic signed [31:0] mq;
  logic signed [31:0] raw, y;
  logic               windup;
  logic               integ_en, deriv_en;

  assign out_free = !out_valid_r || !out_stall;

  pid_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  assign in_stall  = ctrl.busy;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r     <= ONE_Q;
      integ_gain_r    <= '0;
      deriv_gain_r    <= '0;
      filter_coeff_r  <= N_RST;
      limit_enable_r  <= 1'b0;
      upper_limit_r   <= ONE_Q;
      lower_limit_r   <= -ONE_Q;
      sample_period_r <= PER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_PROP:   prop_gain_r     <= cfg_data;
        REG_INTEG:  integ_gain_r    <= cfg_data;
        REG_DERIV:  deriv_gain_r    <= cfg_data;
        REG_FILTER: filter_coeff_r  <= cfg_data[30:0];
        REG_LIM_EN: limit_enable_r  <= cfg_data[0];
        REG_UPPER:  upper_limit_r   <= cfg_data;
        REG_LOWER:  lower_limit_r   <= cfg_data;
        REG_PERIOD: sample_period_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Multiplier operand select
  always_comb begin
    case (ctrl.uc.ma)
      MA_N:    mul_a = {2'b00, filter_coeff_r};
      MA_P:    mul_a = {prop_gain_r[31], prop_gain_r};
      MA_I:    mul_a = {integ_gain_r[31], integ_gain_r};
      MA_D:    mul_a = {deriv_gain_r[31], deriv_gain_r};
      MA_PER:  mul_a = {16'd0, sample_period_r};
      MA_DN:   mul_a = {dn_r[31], dn_r};
      default: mul_a = '0;
    endcase
    case (ctrl.uc.mb)
      MB_FILT:  mul_b = {filt_r[31], filt_r};
      MB_E:     mul_b = {e_r[31], e_r};
      MB_INTEG: mul_b = {integ_r[31], integ_r};
      MB_N:     mul_b = {2'b00, filter_coeff_r};
      MB_DIFF:  mul_b = {diff_r[31], diff_r};
      default:  mul_b = '0;
    endcase
  end

  // Shared multiplier, product registered every cycle
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Scale back (floor) and saturate
  assign prod_sh = prod_r >>> FRAC_BITS;
  assign mq      = sat66(prod_sh);

  // Output forming and anti-windup decision
  assign raw = sat34(acc_r);
  always_comb begin
    y = raw;
    if (limit_enable_r) begin
      if (y < lower_limit_r) y = lower_limit_r;
      if (y > upper_limit_r) y = upper_limit_r;
    end
  end
  assign windup = limit_enable_r &&
                  ((raw > upper_limit_r && e_r > 0) || (raw < lower_limit_r && e_r < 0));
  assign integ_en = (integ_gain_r != '0);
  assign deriv_en = (deriv_gain_r != '0);

  // Datapath payload registers
  always_ff @(posedge clk) begin
    if (ctrl.go) begin
      if (ctrl.uc.cond == COND_IN) e_r <= in_error_value;
      if (ctrl.uc.do_diff) diff_r <= sat34(34'(e_r) - 34'(t_r));
      if (ctrl.uc.do_out) out_r <= y;
      case (ctrl.uc.wb)
        WB_T:        t_r   <= mq;
        WB_ACC_LOAD: acc_r <= 34'(mq);
        WB_ACC_ADD:  acc_r <= acc_r + 34'(mq);
        WB_DN:       dn_r  <= mq;
        default: ;
      endcase
    end
  end

  // Controller states
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      filt_r  <= '0;
    end else if (ctrl.go) begin
      if (ctrl.uc.do_filt && deriv_en) filt_r <= sat34(34'(filt_r) + 34'(t_r));
      if (ctrl.uc.wb == WB_INTEG && integ_en && !windup) begin
        integ_r <= sat34(34'(integ_r) + 34'(mq));
      end
    end
  end

  // Result item valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.go && ctrl.uc.do_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_control_output = out_r;

  // Checks
  `PID_ASSERT_NXT(a_accept_starts, in_valid && !in_stall, ctrl.busy, "accepted item did not start the program")
  `PID_ASSERT_IMP(a_result_from_work, $rose(out_valid_r), $past(ctrl.busy), "result appeared without work")
  `PID_ASSERT_IMP(a_clamp_holds, $rose(out_valid_r) && limit_enable_r && (lower_limit_r <= upper_limit_r), (out_r >= lower_limit_r) && (out_r <= upper_limit_r), "clamped result outside limits")
  `PID_ASSERT_IMP(a_no_result_drop, ctrl.go && ctrl.uc.do_out && out_valid_r, !out_stall, "waiting result overwritten")

endmodule

@@ sv/pid_useq.sv @@
// Microcode sequencer of the PID controller: step counter, control ROM, waits and jumps.
module pid_useq
  import pid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_free,
  output pid_ctrl_t ctrl
);

  logic [UC_STEP_W-1:0] step_r, step_nxt;
  ucw_t                 ucw;
  logic                 go;

  assign ucw = uc_rom(step_r);

  // Step executes once its wait condition is met
  always_comb begin
    case (ucw.cond)
      COND_IN:  go = in_valid;
      COND_OUT: go = out_free;
      default:  go = 1'b1;
    endcase
  end

  // Next step: hold, jump or advance
  always_comb begin
    step_nxt = step_r;
    if (go) begin
      if (ucw.jump) begin
        step_nxt = ucw.target;
      end else begin
        step_nxt = step_r + UC_STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctrl.uc   = ucw;
  assign ctrl.go   = go;
  assign ctrl.busy = (ucw.cond != COND_IN);

endmodule

@@ tb/sv/pid_controller_with_antiwindup_checker.sv @@
// Checker for the PID controller: watches all channels, predicts each drive value and compares.
`timescale 1ns / 1ps

module pid_output_checker
  import pid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic signed [31:0]   in_error_value,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic signed [31:0]   out_control_output,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   n_fail,
  output int                   n_pending,
  output int                   n_checked
);

  localparam int     FRAC    = PID_FRAC_BITS;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  // controller settings as last written
  longint gain_p, gain_i, gain_d, coef_n, lim_hi, lim_lo, step_dt;
  logic   clamp_on;
  // controller state
  longint integ_acc, filt_acc;

  // drive values still owed by the block, oldest first
  logic [31:0] drive_q[$];
  int          errs;
  int          checks;

  function automatic longint sat_s32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // fixed-point product: exact, floor shift, saturate
  function automatic longint fx_mul(input longint a, input longint b);
    return sat_s32((a * b) >>> FRAC);
  endfunction

  task automatic load_defaults();
    gain_p    = longint'(1) << FRAC;
    gain_i    = 0;
    gain_d    = 0;
    coef_n    = longint'(100) << FRAC;
    clamp_on  = 1'b0;
    lim_hi    = longint'(1) << FRAC;
    lim_lo    = -(longint'(1) << FRAC);
    step_dt   = ((longint'(1) << FRAC) + 500) / 1000;
    integ_acc = 0;
    filt_acc  = 0;
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
    case (cfg_idx_t'(idx))
      REG_PROP:   gain_p   = longint'($signed(v));
      REG_INTEG:  gain_i   = longint'($signed(v));
      REG_DERIV:  gain_d   = longint'($signed(v));
      REG_FILTER: coef_n   = longint'({33'd0, v[30:0]});
      REG_LIM_EN: clamp_on = v[0];
      REG_UPPER:  lim_hi   = longint'($signed(v));
      REG_LOWER:  lim_lo   = longint'($signed(v));
      REG_PERIOD: step_dt  = longint'({47'd0, v[16:0]});
      default: ;
    endcase
  endtask

  // one controller step: drive value from the present state, then Euler update
  function automatic logic [31:0] next_drive(input longint e);
    longint p_t, i_t, d_t, diff, raw, y, rate;
    p_t  = fx_mul(gain_p, e);
    i_t  = 0;
    d_t  = 0;
    diff = sat_s32(e - fx_mul(coef_n, filt_acc));
    if (gain_i != 0) i_t = fx_mul(gain_i, integ_acc);
    if (gain_d != 0) d_t = fx_mul(fx_mul(gain_d, coef_n), diff);
    raw = sat_s32(p_t + i_t + d_t);
    y = raw;
    if (clamp_on) begin
      if (y < lim_lo) y = lim_lo;
      if (y > lim_hi) y = lim_hi;
    end
    // anti-windup: hold the integral while saturated and e pushes further out
    if (gain_i != 0) begin
      rate = e;
      if (clamp_on && ((raw > lim_hi && e > 0) || (raw < lim_lo && e < 0))) rate = 0;
      integ_acc = sat_s32(integ_acc + fx_mul(step_dt, rate));
    end
    if (gain_d != 0) filt_acc = sat_s32(filt_acc + fx_mul(step_dt, diff));
    return y[31:0];
  endfunction

  task automatic flag_error(input string what);
    $display("ERROR %0t ns: %s", $time, what);
    errs++;
  endtask

  task automatic check_drive(input logic [31:0] got);
    logic [31:0] want;
    if (drive_q.size() == 0) begin
      flag_error($sformatf("control_output 0x%08h with no item outstanding", got));
    end else begin
      want = drive_q.pop_front();
      if (got !== want)
        flag_error($sformatf("result %0d: control_output 0x%08h, expected 0x%08h",
                             checks, got, want));
      checks++;
    end
  endtask

  // handshakes in order: settings, results, then new items
  always @(posedge clk) begin
    if (!rst_n) begin
      load_defaults();
      drive_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_setting(cfg_index, cfg_data);
      if (out_valid && !out_stall) check_drive(out_control_output);
      if (in_valid && !in_stall) begin
        drive_q.push_back(next_drive(longint'(in_error_value)));
      end
    end
    n_pending <= drive_q.size();
    n_fail    <= errs;
    n_checked <= checks;
  end

endmodule

@@ tb/sv/pid_controller_with_antiwindup_tb.sv @@
// Top of the PID controller testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module pid_controller_with_antiwindup_tb;
  import pid_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int SETTLE      = 12;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [31:0]   in_error_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [31:0]   out_control_output;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  int n_fail, n_pending, n_checked;
  int snd_idle = 35;
  int rcv_idle = 85;
  int cycles = 0;
  int n_items = 0;
  int n_settings = 0;

  pid_controller_with_antiwindup dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_error_value     (in_error_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_control_output (out_control_output),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  pid_output_checker drive_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_error_value     (in_error_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_control_output (out_control_output),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .n_fail             (n_fail),
    .n_pending          (n_pending),
    .n_checked          (n_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side backpressure
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < rcv_idle);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, n_pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // one error sample; returns at the edge where it was taken, valid still high
  task automatic send_error(input logic [31:0] e);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_error_value <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
  endtask

  // stop sending and wait until every drive value is back and the block is idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // full register set; unused upper data bits carry junk
  task automatic apply_settings(input logic [31:0] p, i, d, n, input logic en,
                                input logic [31:0] hi, lo, dt);
    logic [31:0] junk;
    junk = $urandom;
    settle();
    write_reg(REG_PROP, p);
    write_reg(REG_INTEG, i);
    write_reg(REG_DERIV, d);
    write_reg(REG_FILTER, {junk[31], n[30:0]});
    write_reg(REG_LIM_EN, {junk[30:0], en});
    write_reg(REG_UPPER, hi);
    write_reg(REG_LOWER, lo);
    write_reg(REG_PERIOD, {junk[14:0], dt[16:0]});
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [31:0] corner_error(input int k);
    case (k)
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hffff_ffff;
      3: return 32'h7fff_ffff;
      4: return 32'h8000_0000;
      5: return 32'h0001_0000;
      6: return 32'hffff_0000;
      7: return 32'h5555_5555;
      default: return 32'haaaa_aaaa;
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    logic [31:0] mag;
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3, 4, 5: begin
        mag = $urandom_range(32'h8_0000);
        return $urandom_range(1) ? -mag : mag;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_error();
    logic [31:0] mag;
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3: begin
        mag = $urandom_range(32'h4_0000);
        return $urandom_range(1) ? -mag : mag;
      end
      4, 5: begin
        mag = $urandom_range(32'h1000);
        return $urandom_range(1) ? -mag : mag;
      end
      6: return $urandom;
      default: return 32'h0;
    endcase
  endfunction

  initial begin
    int          k, ph, run_left;
    logic [31:0] base, e, hi, lo, n_val, dt_val;
    logic        en_val;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: pure proportional path at the field extremes
    for (k = 0; k < 9; k++) send_error(corner_error(k));

    // saturating gains, zero N, zero period, clamping on
    apply_settings(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'h0, 1'b1,
                   32'h0010_0000, 32'hfff0_0000, 32'h0);
    send_error(32'h7fff_ffff);
    send_error(32'h8000_0000);
    send_error(32'h0020_0000);
    send_error(32'hffe0_0000);

    // crossed limits, largest N and D, period beyond one second
    apply_settings(32'h0002_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1,
                   32'hffff_0000, 32'h0001_0000, 32'h1_ffff);
    send_error(32'h0004_0000);
    send_error(32'hfffc_0000);
    send_error(32'h7fff_ffff);
    send_error(32'h8000_0000);
    send_error(32'h0);

    // anti-windup: drive past each limit in turn
    apply_settings(32'h0001_0000, 32'h0004_0000, 32'h0, 32'h0064_0000, 1'b1,
                   32'h0002_0000, 32'hfffe_0000, 32'h0001_0000);
    repeat (3) send_error(32'h0003_0000);
    repeat (3) send_error(32'hfffd_0000);

    // random phases: runs of similar error with random settings
    run_left = 0;
    base = '0;
    for (ph = 0; ph < PHASES; ph++) begin
      n_val = ($urandom_range(5) == 0) ? 32'h1 :
              ($urandom_range(4) == 0) ? 32'h7fff_ffff :
              ($urandom_range(6) == 0) ? 32'h0 :
              32'($urandom_range(32'h64_0000, 32'h1_0000));
      en_val = ($urandom_range(9) < 7);
      case ($urandom_range(5))
        0: begin
          hi = 32'h7fff_ffff;
          lo = 32'h8000_0000;
        end
        1: begin  // crossed
          hi = -(32'($urandom_range(32'h4_0000)) + 32'h1);
          lo = $urandom_range(32'h4_0000);
        end
        2: begin  // equal
          hi = $urandom_range(32'h4_0000) - 32'h2_0000;
          lo = hi;
        end
        3: begin
          hi = $urandom;
          lo = $urandom;
        end
        default: begin
          hi = $urandom_range(32'h10_0000, 1);
          lo = -32'($urandom_range(32'h10_0000, 1));
        end
      endcase
      case ($urandom_range(7))
        0: dt_val = 32'h1;
        1: dt_val = 32'h1_0000;
        2: dt_val = 32'h0;
        3: dt_val = 32'h1_ffff;
        default: dt_val = $urandom_range(4000, 1);
      endcase
      apply_settings(pick_gain(), pick_gain(), pick_gain(), n_val, en_val, hi, lo, dt_val);

      // sender/receiver idling by third of the run
      if (ph < PHASES / 3) begin
        snd_idle = 35;
        rcv_idle = 85;
      end else if (ph < 2 * PHASES / 3) begin
        snd_idle = 85;
        rcv_idle = 35;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end

      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (run_left == 0) begin
          run_left = $urandom_range(24, 1);
          base = pick_error();
        end
        run_left--;
        if ($urandom_range(7) == 0) e = $urandom;
        else e = base + 32'($urandom_range(32'h1000)) - 32'h800;
        send_error(e);
        // occasional full drain mid-phase
        if ($urandom_range(63) == 0) settle();
      end
    end

    settle();
    $display("Summary: %0d error samples over %0d controller settings, %0d drive values compared",
             n_items, n_settings, n_checked);
    $display("Summary: clamping with crossed and equal limits, anti-windup, zero gains, N and period");
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/pid_pkg.sv
sv/pid_useq.sv
sv/pid_controller_with_antiwindup.sv
tb/sv/pid_controller_with_antiwindup_checker.sv
tb/sv/pid_controller_with_antiwindup_tb.sv
